[sv/iat_pkg.sv]
// ----------------------------------------------------------------------------
// iat_pkg: shared types and constants of the interface adapter timers
// Word formats of the request and response channels, operation codes,
// register map indexes and control/flag bit positions.
// ----------------------------------------------------------------------------
package iat_pkg;

    // Operation codes of a request word
    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_READ  = 2'd1,
        OP_WRITE = 2'd2
    } t_opcode;

    // Register map
    localparam logic [3:0] REG_PORT_A   = 4'd0;
    localparam logic [3:0] REG_PORT_B   = 4'd1;
    localparam logic [3:0] REG_DIR_A    = 4'd2;
    localparam logic [3:0] REG_DIR_B    = 4'd3;
    localparam logic [3:0] REG_TA_LO    = 4'd4;
    localparam logic [3:0] REG_TA_HI    = 4'd5;
    localparam logic [3:0] REG_TB_LO    = 4'd6;
    localparam logic [3:0] REG_TB_HI    = 4'd7;
    localparam logic [3:0] REG_ICR      = 4'd13;
    localparam logic [3:0] REG_CRA      = 4'd14;
    localparam logic [3:0] REG_CRB      = 4'd15;

    // Control register bits
    localparam int CTRL_START_BIT   = 0;
    localparam int CTRL_ONESHOT_BIT = 3;
    localparam int CTRL_LOAD_BIT    = 4;

    // Interrupt control bits
    localparam int IEN_WIDTH        = 5;
    localparam int ICR_SET_BIT      = 7;
    localparam int FLAG_SUMMARY_BIT = 7;

    // Request word
    typedef struct packed {
        logic [1:0] opcode;
        logic [3:0] reg_address;
        logic [7:0] write_data;
    } t_req;

    // Response word
    typedef struct packed {
        logic [7:0] read_data;
        logic       irq;
    } t_rsp;

    // Per-timer strobes from the register decode
    typedef struct packed {
        logic tick;
        logic wr_latch_lo;
        logic wr_latch_hi;
        logic wr_control;
    } t_timer_ctl;

endpackage

[sv/iat_stream_if.sv]
// ----------------------------------------------------------------------------
// iat_stream_if: valid/ready channel carrying one word
// The source drives valid and payload, the sink drives ready.
// ----------------------------------------------------------------------------
interface iat_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[sv/interface_adapter_timers_core.sv]
// ----------------------------------------------------------------------------
// interface_adapter_timers_core: register map, two interval timers, interrupts
// Sixteen-entry register map with ports, directions, two timers and the
// interrupt mask and flags, behind a valid/ready request/response pair.
// ----------------------------------------------------------------------------
// One request word (tick, register read or register write) is taken every
// clock cycle unless the output is stalled, and its response word appears in
// the output register in the next cycle. The response register is the only
// stage: the timer decrement, the register decode and the read multiplexer
// all settle between the state registers and it, so a request is accepted
// whenever the output register is empty or being emptied in the same cycle.
// Reading the interrupt control register returns the flags and clears them.
module interface_adapter_timers_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    iat_stream_if.sink   i_req,
    iat_stream_if.source o_rsp
);

    iat_pkg::t_req             w_req;
    logic                      w_acc;
    logic                      w_tick, w_rd, w_wr;
    iat_pkg::t_timer_ctl [1:0] w_tctl;
    logic [15:0]               w_count [2];
    logic [7:0]                w_control [2];
    logic [1:0]                w_uf;

    logic [7:0]                r_port_a, n_port_a;
    logic [7:0]                r_port_b, n_port_b;
    logic [7:0]                r_dir_a, n_dir_a;
    logic [7:0]                r_dir_b, n_dir_b;
    logic [iat_pkg::IEN_WIDTH-1:0] r_ien, n_ien;
    logic [7:0]                r_flags, n_flags;
    logic                      r_out_valid;
    iat_pkg::t_rsp             r_out, n_out;
    logic                      w_irq;
    logic [7:0]                w_rdata;

    // Accept whenever the output register can take the response
    assign w_req       = i_req.payload;
    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign w_acc       = i_req.valid && i_req.ready;
    assign w_tick = w_acc && (w_req.opcode == iat_pkg::OP_TICK);
    assign w_rd   = w_acc && (w_req.opcode == iat_pkg::OP_READ);
    assign w_wr   = w_acc && (w_req.opcode == iat_pkg::OP_WRITE);

    // Decode timer strobes
    always_comb begin
        w_tctl[0].tick        = w_tick;
        w_tctl[0].wr_latch_lo = w_wr && (w_req.reg_address == iat_pkg::REG_TA_LO);
        w_tctl[0].wr_latch_hi = w_wr && (w_req.reg_address == iat_pkg::REG_TA_HI);
        w_tctl[0].wr_control  = w_wr && (w_req.reg_address == iat_pkg::REG_CRA);
        w_tctl[1].tick        = w_tick;
        w_tctl[1].wr_latch_lo = w_wr && (w_req.reg_address == iat_pkg::REG_TB_LO);
        w_tctl[1].wr_latch_hi = w_wr && (w_req.reg_address == iat_pkg::REG_TB_HI);
        w_tctl[1].wr_control  = w_wr && (w_req.reg_address == iat_pkg::REG_CRB);
    end

    iat_timer u_timer_a (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_tctl[0]),
        .i_data      (w_req.write_data),
        .o_count     (w_count[0]),
        .o_control   (w_control[0]),
        .o_underflow (w_uf[0])
    );

    iat_timer u_timer_b (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_tctl[1]),
        .i_data      (w_req.write_data),
        .o_count     (w_count[1]),
        .o_control   (w_control[1]),
        .o_underflow (w_uf[1])
    );

    assign w_irq = |(w_uf & r_ien[1:0]);

    // Select the read byte
    always_comb begin
        case (w_req.reg_address)
            iat_pkg::REG_PORT_A: w_rdata = r_port_a;
            iat_pkg::REG_PORT_B: w_rdata = r_port_b;
            iat_pkg::REG_DIR_A:  w_rdata = r_dir_a;
            iat_pkg::REG_DIR_B:  w_rdata = r_dir_b;
            iat_pkg::REG_TA_LO:  w_rdata = w_count[0][7:0];
            iat_pkg::REG_TA_HI:  w_rdata = w_count[0][15:8];
            iat_pkg::REG_TB_LO:  w_rdata = w_count[1][7:0];
            iat_pkg::REG_TB_HI:  w_rdata = w_count[1][15:8];
            iat_pkg::REG_ICR:    w_rdata = r_flags;
            iat_pkg::REG_CRA:    w_rdata = w_control[0];
            iat_pkg::REG_CRB:    w_rdata = w_control[1];
            default:             w_rdata = 8'd0;
        endcase
    end

    // Update ports, mask and flags
    always_comb begin
        n_port_a = r_port_a;
        n_port_b = r_port_b;
        n_dir_a  = r_dir_a;
        n_dir_b  = r_dir_b;
        n_ien    = r_ien;
        n_flags  = r_flags;
        if (w_wr) begin
            case (w_req.reg_address)
                iat_pkg::REG_PORT_A: n_port_a = w_req.write_data;
                iat_pkg::REG_PORT_B: n_port_b = w_req.write_data;
                iat_pkg::REG_DIR_A:  n_dir_a  = w_req.write_data;
                iat_pkg::REG_DIR_B:  n_dir_b  = w_req.write_data;
                iat_pkg::REG_ICR: begin
                    if (w_req.write_data[iat_pkg::ICR_SET_BIT]) begin
                        n_ien = r_ien | w_req.write_data[iat_pkg::IEN_WIDTH-1:0];
                    end else begin
                        n_ien = r_ien & ~w_req.write_data[iat_pkg::IEN_WIDTH-1:0];
                    end
                end
                default: ;
            endcase
        end
        if (w_rd && (w_req.reg_address == iat_pkg::REG_ICR)) begin
            n_flags = 8'd0;
        end
        if (w_tick) begin
            n_flags[1:0] = r_flags[1:0] | w_uf;
            n_flags[iat_pkg::FLAG_SUMMARY_BIT] = r_flags[iat_pkg::FLAG_SUMMARY_BIT] | w_irq;
        end
    end

    // Build the response word
    always_comb begin
        n_out.read_data = w_rd ? w_rdata : 8'd0;
        n_out.irq       = w_tick && w_irq;
    end

    // Hold register state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_port_a <= '0;
            r_port_b <= '0;
            r_dir_a  <= '0;
            r_dir_b  <= '0;
            r_ien    <= '0;
            r_flags  <= '0;
        end else begin
            r_port_a <= n_port_a;
            r_port_b <= n_port_b;
            r_dir_a  <= n_dir_a;
            r_dir_b  <= n_dir_b;
            r_ien    <= n_ien;
            r_flags  <= n_flags;
        end
    end

    // Output register: load on accept, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_acc) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_out <= n_out;
        end
    end

    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.payload = r_out;

endmodule

[sv/iat_timer.sv]
// ----------------------------------------------------------------------------
// iat_timer: one 16-bit down-counting interval timer
// Holds latch, count and control; decrements on a tick while started,
// reloads or stops at zero and reports the underflow in the same cycle.
// ----------------------------------------------------------------------------
module iat_timer (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  iat_pkg::t_timer_ctl i_ctl,
    input  logic [7:0]        i_data,
    output logic [15:0]       o_count,
    output logic [7:0]        o_control,
    output logic              o_underflow
);

    logic [15:0] r_latch, n_latch;
    logic [15:0] r_count, n_count;
    logic [7:0]  r_control, n_control;
    logic [15:0] w_dec;
    logic        w_run;

    assign w_run = i_ctl.tick && r_control[iat_pkg::CTRL_START_BIT];
    assign w_dec = r_count - 16'd1;
    assign o_underflow = w_run && (w_dec == 16'd0);

    // Decrement, reload or stop; take latch and control writes
    always_comb begin
        n_latch   = r_latch;
        n_count   = r_count;
        n_control = r_control;
        if (i_ctl.wr_latch_lo) begin
            n_latch[7:0] = i_data;
        end
        if (i_ctl.wr_latch_hi) begin
            n_latch[15:8] = i_data;
        end
        if (i_ctl.wr_control) begin
            if (i_data[iat_pkg::CTRL_LOAD_BIT]) begin
                n_count = r_latch;
            end
            n_control = i_data;
            n_control[iat_pkg::CTRL_LOAD_BIT] = 1'b0;
        end
        if (w_run) begin
            n_count = w_dec;
            if (w_dec == 16'd0) begin
                if (r_control[iat_pkg::CTRL_ONESHOT_BIT]) begin
                    n_control[iat_pkg::CTRL_START_BIT] = 1'b0;
                end else begin
                    n_count = r_latch;
                end
            end
        end
    end

    // Hold timer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_latch   <= '0;
            r_count   <= '0;
            r_control <= '0;
        end else begin
            r_latch   <= n_latch;
            r_count   <= n_count;
            r_control <= n_control;
        end
    end

    assign o_count   = r_count;
    assign o_control = r_control;

endmodule

[sv/iat_checker.sv]
// ----------------------------------------------------------------------------
// iat_checker: port-level checks of the interface adapter timers
// Watches the request and response channels of the top level; bound to it.
// ----------------------------------------------------------------------------
module iat_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic [1:0] i_in_opcode,
    input logic [3:0] i_in_address,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_read_data,
    input logic       i_out_irq
);

    logic w_in_acc;
    logic w_rd_icr;

    assign w_in_acc = i_in_valid && i_in_ready;
    assign w_rd_icr = w_in_acc && (i_in_opcode == iat_pkg::OP_READ)
                      && (i_in_address == iat_pkg::REG_ICR);

    // A stalled response word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_read_data)
                                        && $stable(i_out_irq))
        else $error("response word changed while stalled");

    // Every accepted word shows its response in the next cycle
    a_out_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> i_out_valid)
        else $error("no response after accepted request");

    // Only reads return data
    a_data_on_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && (i_in_opcode != iat_pkg::OP_READ) |=> i_out_read_data == 8'd0)
        else $error("read data on non-read request");

    // Only ticks raise irq
    a_irq_on_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && (i_in_opcode != iat_pkg::OP_TICK) |=> !i_out_irq)
        else $error("irq on non-tick request");

    // Reading the flags clears them
    a_flags_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rd_icr ##1 w_rd_icr |=> i_out_read_data == 8'd0)
        else $error("interrupt flags not cleared by read");

endmodule

bind interface_adapter_timers_core iat_checker u_iat_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_req.valid),
    .i_in_ready      (i_req.ready),
    .i_in_opcode     (i_req.payload.opcode),
    .i_in_address    (i_req.payload.reg_address),
    .i_out_valid     (o_rsp.valid),
    .i_out_ready     (o_rsp.ready),
    .i_out_read_data (o_rsp.payload.read_data),
    .i_out_irq       (o_rsp.payload.irq)
);
